>>> rtl/dli_pkg.sv
`timescale 1ns / 1ps
package dli_pkg;

  // Beat widths on the stream ports.
  localparam int InDataW  = 80;
  localparam int InUserW  = 2;
  localparam int OutDataW = 72;

  localparam int CmdSlots = 256;
  localparam int CmdIdxW  = $clog2(CmdSlots);

  // Kinds of input beats, carried in the input tuser.
  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_WORD  = 2'd2,
    OP_NONE  = 2'd3
  } item_kind_t;

  // Register offsets within the block window.
  localparam logic [11:0] OFS_ZERO   = 12'h004;
  localparam logic [11:0] OFS_HWSIZE = 12'h008;
  localparam logic [11:0] OFS_LSTAT  = 12'h100;
  localparam logic [11:0] OFS_LADDR  = 12'h108;
  localparam logic [11:0] OFS_STALL  = 12'h10C;
  localparam logic [11:0] OFS_LINK0  = 12'h110;
  localparam logic [11:0] OFS_LINK1  = 12'h114;
  localparam logic [11:0] OFS_VTX    = 12'h118;
  localparam logic [11:0] OFS_IDX    = 12'h11C;
  localparam logic [11:0] OFS_ORG0   = 12'h120;
  localparam logic [11:0] OFS_ORG1   = 12'h124;
  localparam logic [11:0] OFS_ORG2   = 12'h128;
  localparam logic [11:0] OFS_CMDST  = 12'h304;
  localparam logic [11:0] OFS_INTST  = 12'h308;
  localparam logic [11:0] OFS_INTTGL = 12'h30C;
  localparam logic [11:0] OFS_CMDSWP = 12'h310;
  localparam logic [11:0] OFS_EDRAM  = 12'h400;
  localparam logic [1:0]  TABLE_WIN  = 2'b10;  // offset bits 11:10 of 0x800..0xBFF

  localparam logic [31:0] HW_SIZE_VALUE = 32'(32'h0020_0000 >> 10);

  // List opcodes.
  localparam logic [7:0] CMD_JUMP   = 8'h08;
  localparam logic [7:0] CMD_END    = 8'h0C;
  localparam logic [7:0] CMD_FINISH = 8'h0F;
  localparam logic [7:0] CMD_BASE   = 8'h10;

  typedef enum logic [4:0] {
    REG_ZERO   = 5'd0,
    REG_HWSIZE = 5'd1,
    REG_LSTAT  = 5'd2,
    REG_LADDR  = 5'd3,
    REG_STALL  = 5'd4,
    REG_LINK0  = 5'd5,
    REG_LINK1  = 5'd6,
    REG_VTX    = 5'd7,
    REG_IDX    = 5'd8,
    REG_ORG0   = 5'd9,
    REG_ORG1   = 5'd10,
    REG_ORG2   = 5'd11,
    REG_CMDST  = 5'd12,
    REG_INTST  = 5'd13,
    REG_INTTGL = 5'd14,
    REG_CMDSWP = 5'd15,
    REG_EDRAM  = 5'd16,
    REG_TABLE  = 5'd17,
    REG_NONE   = 5'd18
  } reg_sel_t;

  // One classified item as it waits in the queue.
  typedef struct packed {
    item_kind_t           kind;
    reg_sel_t             sel;
    logic                 err;
    logic [CmdIdxW-1:0]   tab_idx;
    logic [31:0]          data;
  } item_t;

  // One result beat.
  typedef struct packed {
    logic        interrupt_line;
    logic        list_busy;
    logic [31:0] fetch_address;
    logic        fetch_request;
    logic        access_error;
    logic [31:0] read_data;
  } result_t;

endpackage

>>> rtl/dli_front.sv
`timescale 1ns / 1ps
module dli_front (
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [dli_pkg::InDataW-1:0] s_tdata,
  input  logic [dli_pkg::InUserW-1:0] s_tuser,
  output logic                       push,
  input  logic                       push_ready,
  output dli_pkg::item_t             item
);
  import dli_pkg::*;

  logic [11:0] offset;
  logic [31:0] wdata;
  logic [31:0] word;
  item_kind_t  kind;
  reg_sel_t    sel;

  assign offset = s_tdata[11:0];
  assign wdata  = s_tdata[43:12];
  assign word   = s_tdata[75:44];
  assign kind   = item_kind_t'(s_tuser);

  assign s_tready = push_ready;
  assign push     = s_tvalid && push_ready;

  always_comb begin
    if (offset[11:10] == TABLE_WIN) begin
      sel = REG_TABLE;
    end else begin
      case (offset)
        OFS_ZERO:   sel = REG_ZERO;
        OFS_HWSIZE: sel = REG_HWSIZE;
        OFS_LSTAT:  sel = REG_LSTAT;
        OFS_LADDR:  sel = REG_LADDR;
        OFS_STALL:  sel = REG_STALL;
        OFS_LINK0:  sel = REG_LINK0;
        OFS_LINK1:  sel = REG_LINK1;
        OFS_VTX:    sel = REG_VTX;
        OFS_IDX:    sel = REG_IDX;
        OFS_ORG0:   sel = REG_ORG0;
        OFS_ORG1:   sel = REG_ORG1;
        OFS_ORG2:   sel = REG_ORG2;
        OFS_CMDST:  sel = REG_CMDST;
        OFS_INTST:  sel = REG_INTST;
        OFS_INTTGL: sel = REG_INTTGL;
        OFS_CMDSWP: sel = REG_CMDSWP;
        OFS_EDRAM:  sel = REG_EDRAM;
        default:    sel = REG_NONE;
      endcase
    end
  end

  always_comb begin
    item.kind    = kind;
    item.sel     = sel;
    item.tab_idx = offset[CmdIdxW+1:2];
    item.data    = (kind == OP_WORD) ? word : wdata;
    case (kind)
      OP_READ:  item.err = (sel == REG_NONE) || (sel == REG_INTTGL) || (sel == REG_CMDSWP);
      OP_WRITE: item.err = (sel == REG_NONE) || (sel == REG_ZERO) || (sel == REG_HWSIZE) ||
                           (sel == REG_CMDST) || (sel == REG_TABLE);
      default:  item.err = 1'b0;
    endcase
  end

endmodule

>>> rtl/dli_queue.sv
`timescale 1ns / 1ps
module dli_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           push_ready,
  input  dli_pkg::item_t push_item,
  output logic           pop_valid,
  input  logic           pop,
  output dli_pkg::item_t pop_item
);
  import dli_pkg::*;

  item_t       slots [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_item   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> rtl/dli_back.sv
`timescale 1ns / 1ps
module dli_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  output logic                        item_pop,
  input  dli_pkg::item_t              item,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [dli_pkg::OutDataW-1:0] m_tdata
);
  import dli_pkg::*;

  logic [31:0] dl_stat;
  logic [31:0] dl_addr;
  logic [31:0] dl_stall;
  logic [31:0] link_addr [2];
  logic [31:0] vtx_base;
  logic [31:0] idx_base;
  logic [31:0] origin_addr [3];
  logic [31:0] cmd_status;
  logic [31:0] int_status;
  logic [31:0] emem_size;
  logic [31:0] base_cmd;

  logic [31:0] dl_stat_next;
  logic [31:0] dl_addr_next;
  logic [31:0] dl_stall_next;
  logic [31:0] cmd_status_next;
  logic [31:0] int_status_next;
  logic [31:0] base_cmd_next;

  logic [31:0]         cmd_mem [CmdSlots];
  logic [CmdSlots-1:0] cmd_valid;
  logic [31:0]         cmd_rd;
  logic                cmd_rd_valid;

  result_t     res;
  logic        res_from_table;
  logic [31:0] rdata_next;
  logic        want_now;
  logic        take_word;
  logic        do_write;
  logic [7:0]  opcode;
  logic [31:0] jump_addr;
  logic [31:0] addr_inc;

  assign item_pop  = item_valid && (!m_tvalid || m_tready);
  assign opcode    = item.data[31:24];
  assign want_now  = dl_stat[0] && ((dl_stall == 32'd0) || (dl_addr < dl_stall));
  assign take_word = item_pop && (item.kind == OP_WORD) && want_now;
  assign do_write  = item_pop && (item.kind == OP_WRITE) && !item.err;
  assign addr_inc  = dl_addr + 32'd4;
  assign jump_addr = {base_cmd_next[23:16], item.data[23:0]};

  // The fetch request in the result sees a stall address written by this item.
  assign dl_stall_next = (do_write && (item.sel == REG_STALL)) ? item.data : dl_stall;

  // Next list status and address, command and interrupt status and base command.
  always_comb begin
    dl_stat_next    = dl_stat;
    dl_addr_next    = dl_addr;
    cmd_status_next = cmd_status;
    int_status_next = int_status;
    base_cmd_next   = base_cmd;
    if (take_word) begin
      dl_addr_next = addr_inc;
      if (opcode == CMD_BASE) begin
        base_cmd_next = item.data;
      end
      case (opcode)
        CMD_JUMP: dl_addr_next = jump_addr;
        CMD_END: begin
          dl_stat_next    = {dl_stat[31:1], 1'b0};
          cmd_status_next = cmd_status | 32'h2;
          int_status_next = int_status | 32'h2;
        end
        CMD_FINISH: begin
          cmd_status_next = cmd_status | 32'h4;
          int_status_next = int_status | 32'h4;
        end
        default: ;
      endcase
    end else if (do_write) begin
      case (item.sel)
        REG_LSTAT:  dl_stat_next    = item.data;
        REG_LADDR:  dl_addr_next    = item.data;
        REG_INTST:  int_status_next = int_status & ~item.data;
        REG_INTTGL: int_status_next = int_status ^ item.data;
        REG_CMDSWP: begin
          cmd_status_next = cmd_status ^ item.data;
          int_status_next = cmd_status ^ item.data;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    rdata_next = 32'd0;
    if (item.kind == OP_READ && !item.err) begin
      case (item.sel)
        REG_HWSIZE: rdata_next = HW_SIZE_VALUE;
        REG_LSTAT:  rdata_next = dl_stat;
        REG_LADDR:  rdata_next = dl_addr;
        REG_STALL:  rdata_next = dl_stall;
        REG_LINK0:  rdata_next = link_addr[0];
        REG_LINK1:  rdata_next = link_addr[1];
        REG_VTX:    rdata_next = vtx_base;
        REG_IDX:    rdata_next = idx_base;
        REG_ORG0:   rdata_next = origin_addr[0];
        REG_ORG1:   rdata_next = origin_addr[1];
        REG_ORG2:   rdata_next = origin_addr[2];
        REG_CMDST:  rdata_next = cmd_status;
        REG_INTST:  rdata_next = int_status;
        REG_EDRAM:  rdata_next = emem_size;
        default:    rdata_next = 32'd0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dl_stat        <= 32'd0;
      dl_addr        <= 32'd0;
      dl_stall       <= 32'd0;
      link_addr[0]   <= 32'd0;
      link_addr[1]   <= 32'd0;
      vtx_base       <= 32'd0;
      idx_base       <= 32'd0;
      origin_addr[0] <= 32'd0;
      origin_addr[1] <= 32'd0;
      origin_addr[2] <= 32'd0;
      cmd_status     <= 32'd0;
      int_status     <= 32'd0;
      emem_size      <= 32'd0;
      base_cmd       <= 32'd0;
    end else begin
      dl_stat    <= dl_stat_next;
      dl_addr    <= dl_addr_next;
      dl_stall   <= dl_stall_next;
      cmd_status <= cmd_status_next;
      int_status <= int_status_next;
      base_cmd   <= base_cmd_next;
      if (do_write) begin
        case (item.sel)
          REG_LINK0: link_addr[0]   <= item.data;
          REG_LINK1: link_addr[1]   <= item.data;
          REG_VTX:   vtx_base       <= item.data;
          REG_IDX:   idx_base       <= item.data;
          REG_ORG0:  origin_addr[0] <= item.data;
          REG_ORG1:  origin_addr[1] <= item.data;
          REG_ORG2:  origin_addr[2] <= item.data;
          REG_EDRAM: emem_size      <= item.data;
          default: ;
        endcase
      end
    end
  end

  // Command table: one write port for fetched words, one registered read port.
  always_ff @(posedge clk) begin
    if (take_word) begin
      cmd_mem[opcode] <= item.data;
    end
    if (item_pop) begin
      cmd_rd <= cmd_mem[item.tab_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid    <= '0;
      cmd_rd_valid <= 1'b0;
    end else begin
      if (take_word) begin
        cmd_valid[opcode] <= 1'b1;
      end
      if (item_pop) begin
        cmd_rd_valid <= cmd_valid[item.tab_idx];
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (item_pop) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_pop) begin
      res.read_data      <= rdata_next;
      res.access_error   <= item.err;
      res.fetch_request  <= dl_stat_next[0] &&
                            ((dl_stall_next == 32'd0) || (dl_addr_next < dl_stall_next));
      res.fetch_address  <= dl_addr_next;
      res.list_busy      <= dl_stat_next[0];
      res.interrupt_line <= (int_status_next != 32'd0);
      res_from_table     <= (item.kind == OP_READ) && !item.err && (item.sel == REG_TABLE);
    end
  end

  always_comb begin
    m_tdata = {4'd0, res};
    if (res_from_table) begin
      m_tdata[31:0] = cmd_rd_valid ? cmd_rd : 32'd0;
    end
  end

endmodule

>>> rtl/display_list_interface_regs_top.sv
`timescale 1ns / 1ps
// A beat accepted at s_* is written into the queue, then executed into the result register
// and presented at m_*. Throughput: one beat per cycle while m_tready stays high; the
// two-entry queue and the result register set that pace.
// Reset (rst, synchronous, active high) clears state registers, the command table valid bits,
// the queue and result valid; the table reads as zero until a list word fills an entry.
module display_list_interface_regs_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // Fields from bit 0 up: reg_offset[11:0], write_data[43:12], list_word[75:44], zero pad.
  input  logic [79:0] s_tdata,
  // Fields from bit 0 up: operation[1:0].
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // Fields from bit 0 up: read_data[31:0], access_error[32], fetch_request[33],
  // fetch_address[65:34], list_busy[66], interrupt_line[67], zero pad.
  output logic [71:0] m_tdata
);
  import dli_pkg::*;

  // The front end decodes each beat into a register select and an error flag.
  // A short queue lets the bus side keep going while the result side stalls.
  logic  push;
  logic  push_ready;
  item_t push_item;
  logic  pop_valid;
  logic  pop;
  item_t pop_item;

  dli_front u_front (
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .push       (push),
    .push_ready (push_ready),
    .item       (push_item)
  );

  dli_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_item   (pop_item)
  );

  // The back end holds all state and the result register; one item per cycle unless it stalls.
  dli_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (pop_valid),
    .item_pop   (pop),
    .item       (pop_item),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

`ifndef SYNTHESIS
  // A fetch is only ever requested while the list is busy.
  a_fetch_needs_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (!m_tdata[33] || m_tdata[66]))
    else $error("fetch request without busy");

  // An access error always returns zero data.
  a_error_zero_data: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[32]) |-> (m_tdata[31:0] == 32'd0))
    else $error("access error with nonzero read data");

  // Nothing leaves the queue while the result register is stalled.
  a_no_pop_on_stall: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !pop)
    else $error("item executed while result stalled");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");
`endif

endmodule

>>> tb/sv/dli_result_checker.sv
`timescale 1ns / 1ps
module dli_result_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [79:0] s_tdata,
  input  logic [1:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [71:0] m_tdata,
  output int          fail_count,
  output int          pending
);
  import dli_pkg::*;

  // Shadow copy of the register file and the per-opcode command table.
  logic [31:0] lstat, laddr, stall, vtx, idx, cmdst, intst, edram;
  logic [31:0] link [2];
  logic [31:0] org [3];
  logic [31:0] cmd_seen [CmdSlots];

  result_t due_results [$];

  function automatic logic fetch_wanted();
    return lstat[0] && (stall == '0 || laddr < stall);
  endfunction

  function automatic void take_list_word(logic [31:0] word);
    logic [7:0] opc;
    opc = word[31:24];
    cmd_seen[opc] = word;
    laddr = laddr + 32'd4;
    case (opc)
      CMD_JUMP: laddr = {cmd_seen[CMD_BASE][23:16], word[23:0]};
      CMD_END: begin
        lstat[0] = 1'b0;
        cmdst[1] = 1'b1;
        intst[1] = 1'b1;
      end
      CMD_FINISH: begin
        cmdst[2] = 1'b1;
        intst[2] = 1'b1;
      end
      default: ;
    endcase
  endfunction

  function automatic logic read_reg(logic [11:0] off, output logic [31:0] val);
    val = '0;
    if (off[11:10] == TABLE_WIN) begin
      val = cmd_seen[off[9:2]];
      return 1'b1;
    end
    case (off)
      OFS_ZERO:   val = '0;
      OFS_HWSIZE: val = HW_SIZE_VALUE;
      OFS_LSTAT:  val = lstat;
      OFS_LADDR:  val = laddr;
      OFS_STALL:  val = stall;
      OFS_LINK0:  val = link[0];
      OFS_LINK1:  val = link[1];
      OFS_VTX:    val = vtx;
      OFS_IDX:    val = idx;
      OFS_ORG0:   val = org[0];
      OFS_ORG1:   val = org[1];
      OFS_ORG2:   val = org[2];
      OFS_CMDST:  val = cmdst;
      OFS_INTST:  val = intst;
      OFS_EDRAM:  val = edram;
      default:    return 1'b0;
    endcase
    return 1'b1;
  endfunction

  function automatic logic write_reg(logic [11:0] off, logic [31:0] d);
    case (off)
      OFS_LSTAT:  lstat = d;
      OFS_LADDR:  laddr = d;
      OFS_STALL:  stall = d;
      OFS_LINK0:  link[0] = d;
      OFS_LINK1:  link[1] = d;
      OFS_VTX:    vtx = d;
      OFS_IDX:    idx = d;
      OFS_ORG0:   org[0] = d;
      OFS_ORG1:   org[1] = d;
      OFS_ORG2:   org[2] = d;
      OFS_INTST:  intst = intst & ~d;
      OFS_INTTGL: intst = intst ^ d;
      OFS_CMDSWP: begin
        cmdst = cmdst ^ d;
        intst = cmdst;
      end
      OFS_EDRAM:  edram = d;
      default:    return 1'b0;
    endcase
    return 1'b1;
  endfunction

  // Applies one input beat to the shadow state and returns the beat it must produce.
  function automatic result_t next_result(item_kind_t kind, logic [11:0] off,
                                          logic [31:0] wdata, logic [31:0] word);
    result_t r;
    logic ok;
    logic [31:0] rd;
    ok = 1'b1;
    rd = '0;
    case (kind)
      OP_READ: begin
        ok = read_reg(off, rd);
        if (!ok) rd = '0;
      end
      OP_WRITE: ok = write_reg(off, wdata);
      OP_WORD: if (fetch_wanted()) take_list_word(word);
      default: ;
    endcase
    r.read_data      = rd;
    r.access_error   = !ok;
    r.fetch_request  = fetch_wanted();
    r.fetch_address  = laddr;
    r.list_busy      = lstat[0];
    r.interrupt_line = |intst;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      fail_count++;
      if (fail_count <= 10)
        $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : watch
    result_t got;
    result_t want;
    if (rst) begin
      lstat = '0;
      laddr = '0;
      stall = '0;
      vtx   = '0;
      idx   = '0;
      cmdst = '0;
      intst = '0;
      edram = '0;
      link[0] = '0;
      link[1] = '0;
      for (int i = 0; i < 3; i++) org[i] = '0;
      for (int i = 0; i < CmdSlots; i++) cmd_seen[i] = '0;
      due_results.delete();
      fail_count = 0;
    end else begin
      // Output side first: a beat accepted now cannot leave in the same cycle.
      if (m_tvalid && m_tready) begin
        got = result_t'(m_tdata[67:0]);
        if (due_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: result beat %h with nothing outstanding", $time, m_tdata);
        end else begin
          want = due_results.pop_front();
          check_field("read_data", want.read_data, got.read_data);
          check_field("access_error", want.access_error, got.access_error);
          check_field("fetch_request", want.fetch_request, got.fetch_request);
          check_field("fetch_address", want.fetch_address, got.fetch_address);
          check_field("list_busy", want.list_busy, got.list_busy);
          check_field("interrupt_line", want.interrupt_line, got.interrupt_line);
        end
      end
      if (s_tvalid && s_tready)
        due_results.push_back(next_result(item_kind_t'(s_tuser), s_tdata[11:0],
                                          s_tdata[43:12], s_tdata[75:44]));
    end
    pending = due_results.size();
  end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
module tb;
  import dli_pkg::*;

  // The run is cut off here if the results stop coming.
  localparam int CycleLimit = 300000;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [79:0] s_tdata;    // reg_offset[11:0], write_data[43:12], list_word[75:44], zero pad
  logic [1:0]  s_tuser;    // operation[1:0]
  logic        m_tvalid;
  logic        m_tready;
  logic [71:0] m_tdata;    // read_data, access_error, fetch_request, fetch_address,
                           // list_busy, interrupt_line, zero pad

  int fail_count;
  int pending;
  int beats_sent = 0;
  bit idle_on = 1'b1;      // random gaps on both sides while set
  int rx_hold_req = 0;     // cycles of back-pressure requested from the receiver

  display_list_interface_regs_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // The checker watches both channels, keeps its own copy of the registers and
  // the command table, and compares every result beat against its prediction.
  dli_result_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog: if the run hangs, it fails here.
  initial begin
    repeat (CycleLimit) @(posedge clk);
    $display("** display_list_interface_regs_top: FAILED **");
    $finish;
  end

  // Receiver. It stalls at random while idling is enabled, and it can be told
  // to hold off for a long stretch so the block fills up and stalls its input.
  // The hold is counted down here, once per falling edge.
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_req > 0) begin
        hold_left = rx_hold_req;
        rx_hold_req = 0;
      end
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else begin
        m_tready <= !(idle_on && $urandom_range(99) < 24);
      end
    end
  end

  // Offers one beat and returns at the falling edge after it was taken. The
  // valid stays high on return, so the next call can follow without a gap;
  // whoever waits instead must lower it first.
  task automatic push_beat(item_kind_t kind, logic [11:0] off, logic [31:0] wdata,
                           logic [31:0] word);
    while (idle_on && $urandom_range(99) < 24) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {4'b0, word, wdata, off};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    beats_sent++;
  endtask

  // Stops offering beats and waits until every predicted result has come out.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  // A mapped offset, or an entry of the command table window.
  function automatic logic [11:0] pick_offset();
    case ($urandom_range(17))
      0:  return OFS_ZERO;
      1:  return OFS_HWSIZE;
      2:  return OFS_LSTAT;
      3:  return OFS_LADDR;
      4:  return OFS_STALL;
      5:  return OFS_LINK0;
      6:  return OFS_LINK1;
      7:  return OFS_VTX;
      8:  return OFS_IDX;
      9:  return OFS_ORG0;
      10: return OFS_ORG1;
      11: return OFS_ORG2;
      12: return OFS_CMDST;
      13: return OFS_INTST;
      14: return OFS_INTTGL;
      15: return OFS_CMDSWP;
      16: return OFS_EDRAM;
      default: return {TABLE_WIN, 10'($urandom)};
    endcase
  endfunction

  // List words with random content, biased toward the opcodes that act.
  function automatic logic [31:0] pick_list_word();
    logic [31:0] w;
    int roll;
    w = $urandom;
    roll = $urandom_range(99);
    if (roll < 5)       w[31:24] = CMD_END;
    else if (roll < 10) w[31:24] = CMD_FINISH;
    else if (roll < 18) w[31:24] = CMD_JUMP;
    else if (roll < 24) w[31:24] = CMD_BASE;
    return w;
  endfunction

  // One beat: mostly a register access at a mapped offset, else any kind at any offset.
  task automatic poke_reg();
    if ($urandom_range(9) < 7)
      push_beat($urandom_range(1) ? OP_WRITE : OP_READ, pick_offset(), $urandom, $urandom);
    else
      push_beat(item_kind_t'(2'($urandom_range(3))), 12'($urandom), $urandom, $urandom);
  endtask

  // A well-formed list program: set the list and stall addresses, start the
  // list, feed it words, and read back some of what it did.
  task automatic run_list(int words);
    logic [31:0] start;
    logic [31:0] stall_at;
    logic [31:0] status;
    start = $urandom & ~32'd3;
    case ($urandom_range(7))
      0: start = 32'hFFFF_FFF0;
      1: start = $urandom;
      default: ;
    endcase
    case ($urandom_range(5))
      0, 1: stall_at = '0;
      2:    stall_at = start + 32'd4 * $urandom_range(1, 12);
      3:    stall_at = start;
      4:    stall_at = $urandom;
      default: stall_at = 32'hFFFF_FFFF;
    endcase
    status = $urandom;
    status[0] = ($urandom_range(9) != 0);
    push_beat(OP_WRITE, OFS_LADDR, start, $urandom);
    push_beat(OP_WRITE, OFS_STALL, stall_at, $urandom);
    push_beat(OP_WRITE, OFS_LSTAT, status, $urandom);
    repeat (words) begin
      if ($urandom_range(9) == 0) poke_reg();
      push_beat(OP_WORD, 12'($urandom), $urandom, pick_list_word());
    end
    push_beat(OP_READ, OFS_LADDR, $urandom, $urandom);
    push_beat(OP_READ, {TABLE_WIN, 10'($urandom)}, $urandom, $urandom);
    if ($urandom_range(1)) push_beat(OP_READ, OFS_INTST, $urandom, $urandom);
  endtask

  initial begin : stimulus
    int seq;
    int roll;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = OP_NONE;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // Directed part. Fixed values, the error cases, then a short list that
    // wraps its address, jumps, finishes and ends.
    push_beat(OP_READ,  OFS_HWSIZE, 32'h0, 32'h0);
    push_beat(OP_READ,  OFS_ZERO,   32'h0, 32'h0);
    // Writes to read-only offsets are rejected.
    push_beat(OP_WRITE, OFS_ZERO,   32'hFFFF_FFFF, 32'h0);
    push_beat(OP_WRITE, OFS_HWSIZE, 32'hFFFF_FFFF, 32'h0);
    push_beat(OP_WRITE, OFS_CMDST,  32'hFFFF_FFFF, 32'h0);
    push_beat(OP_WRITE, 12'h800,    32'hFFFF_FFFF, 32'h0);
    // An unmapped offset and reads of the write-only offsets are rejected too.
    push_beat(OP_READ,  12'hFFF,    32'h0, 32'h0);
    push_beat(OP_READ,  OFS_INTTGL, 32'h0, 32'h0);
    push_beat(OP_READ,  OFS_CMDSWP, 32'h0, 32'h0);
    // The last table entry through an unaligned offset; still zero after reset.
    push_beat(OP_READ,  12'hBFF,    32'h0, 32'h0);
    // A list word nobody asked for is dropped.
    push_beat(OP_WORD,  12'h0,      32'h0, 32'hFFFF_FFFF);
    // Start a list just below the top of the address space.
    push_beat(OP_WRITE, OFS_LADDR,  32'hFFFF_FFF8, 32'h0);
    push_beat(OP_WRITE, OFS_STALL,  32'h0, 32'h0);
    push_beat(OP_WRITE, OFS_LSTAT,  32'hFFFF_FFFF, 32'h0);
    push_beat(OP_WORD,  12'h0,      32'h0, {CMD_BASE, 24'hABCDEF});
    // This word wraps the list address to zero.
    push_beat(OP_WORD,  12'h0,      32'h0, 32'hFF00_0000);
    // The jump takes its high byte from the base command just stored.
    push_beat(OP_WORD,  12'h0,      32'h0, {CMD_JUMP, 24'h123456});
    push_beat(OP_WORD,  12'h0,      32'h0, {CMD_FINISH, 24'h0});
    push_beat(OP_WORD,  12'h0,      32'h0, {CMD_END, 24'hFFFFFF});
    // Busy is clear now, so this word is dropped as well.
    push_beat(OP_WORD,  12'h0,      32'h0, 32'h0);
    push_beat(OP_NONE,  OFS_LSTAT,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_beat(OP_READ,  12'h830,    32'h0, 32'h0);
    // Toggle every interrupt bit, clear them all, then copy command status back.
    push_beat(OP_WRITE, OFS_INTTGL, 32'hFFFF_FFFF, 32'h0);
    push_beat(OP_WRITE, OFS_INTST,  32'hFFFF_FFFF, 32'h0);
    push_beat(OP_WRITE, OFS_CMDSWP, 32'h0, 32'h0);
    push_beat(OP_READ,  OFS_CMDST,  32'h0, 32'h0);
    push_beat(OP_READ,  OFS_INTST,  32'h0, 32'h0);

    // Random part. Mostly list programs, then register traffic and noise.
    seq = 0;
    while (beats_sent < 725) begin
      // A long stretch runs with no gaps on either side.
      idle_on = !(beats_sent >= 400 && beats_sent < 520);
      // Once, the receiver holds off long enough for the input to back up.
      if (seq == 8) rx_hold_req = 200;
      // The sender pauses until all results are out, once for sure and now and then.
      if (seq == 14 || $urandom_range(29) == 0) drain_results();
      roll = $urandom_range(99);
      if (roll < 60)
        run_list($urandom_range(4, 24));
      else if (roll < 85)
        repeat ($urandom_range(1, 6)) poke_reg();
      else
        repeat ($urandom_range(1, 4))
          push_beat(item_kind_t'(2'($urandom_range(3))), 12'($urandom), $urandom, $urandom);
      seq++;
    end

    // Let everything drain, then leave time for any stray beat to show up.
    drain_results();
    repeat (20) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("** display_list_interface_regs_top: PASSED **");
    end else begin
      $display("** display_list_interface_regs_top: FAILED **");
    end
    $finish;
  end

endmodule
